// ===== design/assert_macros.svh =====
// Assertion macros used by the port-level checker of the timer block.
// Depends on nothing; include this header by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held low.
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed in timer checker");

// Clocked assertion that is checked during reset as well.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed in timer checker");

`endif

// ===== design/pit_pkg.sv =====
// Shared types and constants of the periodic interval timer.
// Used by the top level, the prescaler and the channel counter modules.
package pit_pkg;

    localparam int DATA_W        = 16;
    localparam int ADDR_W        = 4;
    localparam int FLAGS_W       = 4;
    localparam int ADDR_CH_SLOTS = 4;
    localparam int NUM_PRESCALERS = 2;
    localparam int CTRL_ENABLE_BIT = 7;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [ADDR_W-1:0] ADDR_CTRL      = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_FORCELOAD = 4'd1;
    localparam logic [ADDR_W-1:0] ADDR_MUX       = 4'd2;
    localparam logic [ADDR_W-1:0] ADDR_INTE      = 4'd3;
    localparam logic [ADDR_W-1:0] ADDR_CHEN      = 4'd4;
    localparam logic [ADDR_W-1:0] ADDR_FLAGS     = 4'd5;
    localparam logic [ADDR_W-1:0] ADDR_MTLOAD0   = 4'd6;
    localparam logic [ADDR_W-1:0] ADDR_MTLOAD1   = 4'd7;
    localparam logic [ADDR_W-1:0] ADDR_CHLOAD0   = 4'd8;
    localparam logic [ADDR_W-1:0] ADDR_COUNT0    = 4'd12;

    typedef struct packed {
        logic load_wr;
        logic restart;
        logic tick;
    } t_pre_ctl;

    typedef struct packed {
        logic load_wr;
        logic reload;
        logic step;
    } t_chan_ctl;

endpackage

// ===== design/pit_prescaler.sv =====
// One prescaler micro-timer: load register and down counter that pulses at zero.
// Depends on pit_pkg for the control struct and the data width.
module pit_prescaler #(
    parameter int PRESCALE_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pit_pkg::t_pre_ctl             i_ctl,
    input  logic [pit_pkg::DATA_W-1:0]    i_wdata,
    output logic [PRESCALE_BITS-1:0]      o_load,
    output logic                          o_pulse
);
    import pit_pkg::*;

    logic [PRESCALE_BITS-1:0] r_load;
    logic [PRESCALE_BITS-1:0] n_load;
    logic [PRESCALE_BITS-1:0] r_count;
    logic [PRESCALE_BITS-1:0] n_count;

    assign o_pulse = i_ctl.tick && (r_count == '0);
    assign o_load  = r_load;

    always_comb begin
        n_load  = r_load;
        n_count = r_count;
        if (i_ctl.load_wr) begin
            n_load = PRESCALE_BITS'(i_wdata);
        end
        if (i_ctl.restart) begin
            n_count = r_load;
        end else if (i_ctl.tick) begin
            n_count = o_pulse ? r_load : r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load  <= '0;
            r_count <= '0;
        end else begin
            r_load  <= n_load;
            r_count <= n_count;
        end
    end

endmodule

// ===== design/pit_channel.sv =====
// One timer channel: load register and down counter that wraps at zero.
// Depends on pit_pkg for the control struct and the data width.
module pit_down_counter #(
    parameter int COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pit_pkg::t_chan_ctl            i_ctl,
    input  logic [pit_pkg::DATA_W-1:0]    i_wdata,
    output logic [COUNT_BITS-1:0]         o_load,
    output logic [COUNT_BITS-1:0]         o_count,
    output logic                          o_wrap
);
    import pit_pkg::*;

    logic [COUNT_BITS-1:0] r_load;
    logic [COUNT_BITS-1:0] n_load;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;

    assign o_wrap  = i_ctl.step && (r_count == '0);
    assign o_load  = r_load;
    assign o_count = r_count;

    always_comb begin
        n_load  = r_load;
        n_count = r_count;
        if (i_ctl.load_wr) begin
            n_load = COUNT_BITS'(i_wdata);
        end
        if (i_ctl.reload) begin
            n_count = r_load;
        end else if (i_ctl.step) begin
            n_count = o_wrap ? r_load : r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load  <= '1;
            r_count <= '1;
        end else begin
            r_load  <= n_load;
            r_count <= n_count;
        end
    end

endmodule

// ===== design/periodic_interval_timer_top.sv =====
// Path: an accepted beat is registered in the input register, and its result beat is
// registered in the output register, from which it is presented until it is taken.
// Throughput: one beat per cycle while results are taken; with a result waiting,
// one more beat is held in the input register before the input side stalls.
// Reset: synchronous, active low, with no further sweep; valid, control and prescaler
// registers clear, channel registers set to all ones; payload registers are not reset.
module periodic_interval_timer_top #(
    parameter int NUM_CHANNELS  = 4,
    parameter int COUNT_BITS    = 16,
    parameter int PRESCALE_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_op,
    input  logic [pit_pkg::ADDR_W-1:0]      i_reg_addr,
    input  logic [pit_pkg::DATA_W-1:0]      i_write_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [pit_pkg::DATA_W-1:0]      o_read_data,
    output logic [pit_pkg::FLAGS_W-1:0]     o_timeout_flags,
    output logic                            o_irq
);
    import pit_pkg::*;

    logic                    r_in_valid;
    t_op                     r_op;
    logic [ADDR_W-1:0]       r_addr;
    logic [DATA_W-1:0]       r_data;

    logic                    r_out_valid;
    logic [DATA_W-1:0]       r_read_data;
    logic [FLAGS_W-1:0]      r_flags_out;
    logic                    r_irq;

    logic                    r_enable;
    logic                    n_enable;
    logic [NUM_CHANNELS-1:0] r_mux;
    logic [NUM_CHANNELS-1:0] n_mux;
    logic [NUM_CHANNELS-1:0] r_inte;
    logic [NUM_CHANNELS-1:0] n_inte;
    logic [NUM_CHANNELS-1:0] r_chen;
    logic [NUM_CHANNELS-1:0] n_chen;
    logic [NUM_CHANNELS-1:0] r_flags;
    logic [NUM_CHANNELS-1:0] n_flags;

    logic                    w_go;
    logic                    w_wr;
    logic                    w_tick;
    logic                    w_is_chload;
    logic                    w_is_count;
    logic [NUM_CHANNELS-1:0] w_wdata_ch;
    logic [NUM_CHANNELS-1:0] w_wrap;
    logic [DATA_W-1:0]       w_read_data;
    logic [FLAGS_W+NUM_CHANNELS-1:0] w_flags_ext;

    t_pre_ctl                w_pre_ctl   [NUM_PRESCALERS];
    logic [PRESCALE_BITS-1:0] w_pre_load [NUM_PRESCALERS];
    logic [NUM_PRESCALERS-1:0] w_pulse;

    t_chan_ctl               w_ch_ctl    [NUM_CHANNELS];
    logic [COUNT_BITS-1:0]   w_ch_load   [NUM_CHANNELS];
    logic [COUNT_BITS-1:0]   w_ch_count  [NUM_CHANNELS];

    assign w_go        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_go;
    assign w_wr        = w_go && (r_op == OP_WRITE);
    assign w_tick      = w_go && (r_op == OP_TICK) && r_enable;
    assign w_is_chload = (r_addr >= ADDR_CHLOAD0) && (r_addr < ADDR_COUNT0);
    assign w_is_count  = (r_addr >= ADDR_COUNT0);
    assign w_wdata_ch  = r_data[NUM_CHANNELS-1:0];

    for (genvar m = 0; m < NUM_PRESCALERS; m++) begin : g_pre
        assign w_pre_ctl[m].load_wr = w_wr && (r_addr == ADDR_MTLOAD0 + ADDR_W'(m));
        assign w_pre_ctl[m].restart = w_wr && (r_addr == ADDR_CTRL) && r_data[m];
        assign w_pre_ctl[m].tick    = w_tick;

        pit_prescaler #(
            .PRESCALE_BITS(PRESCALE_BITS)
        ) u_pre (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_pre_ctl[m]),
            .i_wdata (r_data),
            .o_load  (w_pre_load[m]),
            .o_pulse (w_pulse[m])
        );
    end

    for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
        assign w_ch_ctl[c].load_wr = w_wr && w_is_chload && (c < ADDR_CH_SLOTS)
                                     && (int'(r_addr[1:0]) == c);
        assign w_ch_ctl[c].reload  = w_wr && r_data[c]
                                     && ((r_addr == ADDR_FORCELOAD)
                                         || ((r_addr == ADDR_CHEN) && !r_chen[c]));
        assign w_ch_ctl[c].step    = r_chen[c] && w_pulse[r_mux[c]];

        pit_down_counter #(
            .COUNT_BITS(COUNT_BITS)
        ) u_ch (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ch_ctl[c]),
            .i_wdata (r_data),
            .o_load  (w_ch_load[c]),
            .o_count (w_ch_count[c]),
            .o_wrap  (w_wrap[c])
        );
    end

    always_comb begin
        n_enable = r_enable;
        n_mux    = r_mux;
        n_inte   = r_inte;
        n_chen   = r_chen;
        n_flags  = r_flags | w_wrap;
        if (w_wr) begin
            priority if (r_addr == ADDR_CTRL) begin
                n_enable = r_data[CTRL_ENABLE_BIT];
            end else if (r_addr == ADDR_MUX) begin
                n_mux = w_wdata_ch;
            end else if (r_addr == ADDR_INTE) begin
                n_inte = w_wdata_ch;
            end else if (r_addr == ADDR_CHEN) begin
                n_chen = w_wdata_ch;
            end else if (r_addr == ADDR_FLAGS) begin
                n_flags = r_flags & ~w_wdata_ch;
            end else begin
                n_enable = r_enable;
            end
        end
    end

    always_comb begin
        w_read_data = '0;
        priority if (r_addr == ADDR_CTRL) begin
            w_read_data = DATA_W'(r_enable) << CTRL_ENABLE_BIT;
        end else if (r_addr == ADDR_MUX) begin
            w_read_data = DATA_W'(r_mux);
        end else if (r_addr == ADDR_INTE) begin
            w_read_data = DATA_W'(r_inte);
        end else if (r_addr == ADDR_CHEN) begin
            w_read_data = DATA_W'(r_chen);
        end else if (r_addr == ADDR_FLAGS) begin
            w_read_data = DATA_W'(r_flags);
        end else if (r_addr == ADDR_MTLOAD0) begin
            w_read_data = DATA_W'(w_pre_load[0]);
        end else if (r_addr == ADDR_MTLOAD1) begin
            w_read_data = DATA_W'(w_pre_load[1]);
        end else if (w_is_chload || w_is_count) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if ((c < ADDR_CH_SLOTS) && (int'(r_addr[1:0]) == c)) begin
                    w_read_data = w_is_count ? DATA_W'(w_ch_count[c])
                                             : DATA_W'(w_ch_load[c]);
                end
            end
        end else begin
            w_read_data = '0;
        end
    end

    assign w_flags_ext = {{FLAGS_W{1'b0}}, n_flags};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_enable    <= 1'b0;
            r_mux       <= '0;
            r_inte      <= '0;
            r_chen      <= '0;
            r_flags     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_enable <= n_enable;
            r_mux    <= n_mux;
            r_inte   <= n_inte;
            r_chen   <= n_chen;
            r_flags  <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op   <= t_op'(i_op);
            r_addr <= i_reg_addr;
            r_data <= i_write_data;
        end
        if (w_go) begin
            r_read_data <= (r_op == OP_READ) ? w_read_data : '0;
            r_flags_out <= w_flags_ext[FLAGS_W-1:0];
            r_irq       <= |(n_flags & n_inte);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_read_data;
    assign o_timeout_flags = r_flags_out;
    assign o_irq           = r_irq;

endmodule

// ===== design/pit_checker.sv =====
// Port-level checker of the periodic interval timer, bound to the top level.
// Depends on pit_pkg for widths and on assert_macros.svh for the assertion macros.
module pit_checker #(
    parameter int NUM_CHANNELS = 4
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [pit_pkg::DATA_W-1:0]      o_read_data,
    input logic [pit_pkg::FLAGS_W-1:0]     o_timeout_flags,
    input logic                            o_irq
);
    import pit_pkg::*;
`include "assert_macros.svh"

    // A waiting result beat holds its payload until it is taken.
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_data)
            && $stable(o_timeout_flags) && $stable(o_irq))

    // With no result waiting, the input side is always open.
    `ASSERT_CLK_RST(a_in_open, i_clk, i_rst_n, !o_out_valid |-> o_in_ready)

    // Reset empties the result register.
    `ASSERT_CLK(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

    // An interrupt comes only with a visible flag when all channels are visible.
    `ASSERT_CLK_RST(a_irq_flag, i_clk, i_rst_n,
        o_out_valid && o_irq && (NUM_CHANNELS <= FLAGS_W) |-> o_timeout_flags != '0)

endmodule

bind periodic_interval_timer_top pit_checker #(
    .NUM_CHANNELS(NUM_CHANNELS)
) u_pit_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_read_data     (o_read_data),
    .o_timeout_flags (o_timeout_flags),
    .o_irq           (o_irq)
);

// ===== verif/periodic_interval_timer_checker.sv =====
`timescale 1ns / 100ps
// Checker for the periodic interval timer: predicts each status beat and compares it.
// Depends on pit_pkg for operation codes, register addresses and field widths.
module periodic_interval_timer_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [1:0]                  i_op,
    input  logic [pit_pkg::ADDR_W-1:0]  i_reg_addr,
    input  logic [pit_pkg::DATA_W-1:0]  i_write_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [pit_pkg::DATA_W-1:0]  i_read_data,
    input  logic [pit_pkg::FLAGS_W-1:0] i_timeout_flags,
    input  logic                        i_irq,
    output int                          o_fail_count,
    output int                          o_outstanding,
    output int                          o_checked
);
    import pit_pkg::*;

    localparam int NUM_CH     = 4;
    localparam int COUNT_W    = 16;
    localparam int PRESCALE_W = 8;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic [FLAGS_W-1:0] flags;
        logic               irq;
    } t_status_beat;

    logic                  timer_on;
    logic [NUM_CH-1:0]     mux_sel;
    logic [NUM_CH-1:0]     irq_en;
    logic [NUM_CH-1:0]     chan_en;
    logic [NUM_CH-1:0]     flags;
    logic [PRESCALE_W-1:0] pre_load [NUM_PRESCALERS];
    logic [PRESCALE_W-1:0] pre_count [NUM_PRESCALERS];
    logic [COUNT_W-1:0]    chan_load [NUM_CH];
    logic [COUNT_W-1:0]    chan_count [NUM_CH];

    t_status_beat status_queue [$];
    t_status_beat want;
    int           fail_count = 0;
    int           checked = 0;

    function automatic t_status_beat advance_timer(t_op op, logic [ADDR_W-1:0] addr,
                                                   logic [DATA_W-1:0] data);
        t_status_beat      beat;
        logic [NUM_CH-1:0] rising;
        logic [1:0]        pulse;
        int                c;
        int                m;
        beat = '0;
        case (op)
            OP_READ: begin
                if (addr == ADDR_CTRL) begin
                    beat.read_data = timer_on ? (DATA_W'(1) << CTRL_ENABLE_BIT) : '0;
                end else if (addr == ADDR_MUX) begin
                    beat.read_data = DATA_W'(mux_sel);
                end else if (addr == ADDR_INTE) begin
                    beat.read_data = DATA_W'(irq_en);
                end else if (addr == ADDR_CHEN) begin
                    beat.read_data = DATA_W'(chan_en);
                end else if (addr == ADDR_FLAGS) begin
                    beat.read_data = DATA_W'(flags);
                end else if (addr == ADDR_MTLOAD0 || addr == ADDR_MTLOAD1) begin
                    beat.read_data = DATA_W'(pre_load[addr[0]]);
                end else if (addr >= ADDR_CHLOAD0) begin
                    c = int'(addr[1:0]);
                    if (c < NUM_CH) begin
                        beat.read_data = (addr >= ADDR_COUNT0) ? DATA_W'(chan_count[c])
                                                               : DATA_W'(chan_load[c]);
                    end
                end
            end
            OP_WRITE: begin
                if (addr == ADDR_CTRL) begin
                    timer_on = data[CTRL_ENABLE_BIT];
                    for (m = 0; m < NUM_PRESCALERS; m++) begin
                        if (data[m]) pre_count[m] = pre_load[m];
                    end
                end else if (addr == ADDR_FORCELOAD) begin
                    for (c = 0; c < NUM_CH; c++) begin
                        if (data[c]) chan_count[c] = chan_load[c];
                    end
                end else if (addr == ADDR_MUX) begin
                    mux_sel = data[NUM_CH-1:0];
                end else if (addr == ADDR_INTE) begin
                    irq_en = data[NUM_CH-1:0];
                end else if (addr == ADDR_CHEN) begin
                    rising = data[NUM_CH-1:0] & ~chan_en;
                    for (c = 0; c < NUM_CH; c++) begin
                        if (rising[c]) chan_count[c] = chan_load[c];
                    end
                    chan_en = data[NUM_CH-1:0];
                end else if (addr == ADDR_FLAGS) begin
                    flags = flags & ~data[NUM_CH-1:0];
                end else if (addr == ADDR_MTLOAD0 || addr == ADDR_MTLOAD1) begin
                    pre_load[addr[0]] = data[PRESCALE_W-1:0];
                end else if (addr >= ADDR_CHLOAD0 && addr < ADDR_COUNT0) begin
                    c = int'(addr[1:0]);
                    if (c < NUM_CH) chan_load[c] = data[COUNT_W-1:0];
                end
            end
            OP_TICK: begin
                if (timer_on) begin
                    for (m = 0; m < NUM_PRESCALERS; m++) begin
                        pulse[m] = (pre_count[m] == '0);
                        pre_count[m] = pulse[m] ? pre_load[m] : pre_count[m] - 1'b1;
                    end
                    for (c = 0; c < NUM_CH; c++) begin
                        if (chan_en[c] && pulse[mux_sel[c]]) begin
                            if (chan_count[c] == '0) begin
                                chan_count[c] = chan_load[c];
                                flags[c] = 1'b1;
                            end else begin
                                chan_count[c] = chan_count[c] - 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        beat.flags = FLAGS_W'(flags);
        beat.irq = |(flags & irq_en);
        return beat;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timer_on = 1'b0;
            mux_sel = '0;
            irq_en = '0;
            chan_en = '0;
            flags = '0;
            for (int m = 0; m < NUM_PRESCALERS; m++) begin
                pre_load[m] = '0;
                pre_count[m] = '0;
            end
            for (int c = 0; c < NUM_CH; c++) begin
                chan_load[c] = '1;
                chan_count[c] = '1;
            end
            status_queue.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (status_queue.size() == 0) begin
                    $error("status beat arrived with no request outstanding");
                    fail_count++;
                end else begin
                    want = status_queue.pop_front();
                    checked++;
                    if (i_read_data !== want.read_data) begin
                        $error("read_data: expected %h, actual %h", want.read_data, i_read_data);
                        fail_count++;
                    end
                    if (i_timeout_flags !== want.flags) begin
                        $error("timeout_flags: expected %h, actual %h", want.flags,
                               i_timeout_flags);
                        fail_count++;
                    end
                    if (i_irq !== want.irq) begin
                        $error("irq: expected %b, actual %b", want.irq, i_irq);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                status_queue.push_back(advance_timer(t_op'(i_op), i_reg_addr, i_write_data));
            end
        end
        o_fail_count <= fail_count;
        o_outstanding <= status_queue.size();
        o_checked <= checked;
    end

endmodule

// ===== verif/periodic_interval_timer_top_tb.sv =====
`timescale 1ns / 100ps
// Top of the periodic interval timer testbench: clock, reset, request and stall stimulus.
// Depends on pit_pkg, periodic_interval_timer_top and periodic_interval_timer_checker.
module periodic_interval_timer_top_tb;
    import pit_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 3;
    localparam int PHASE_BEATS  = 500;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic [1:0]         i_op = OP_NONE;
    logic [ADDR_W-1:0]  i_reg_addr = '0;
    logic [DATA_W-1:0]  i_write_data = '0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [DATA_W-1:0]  o_read_data;
    logic [FLAGS_W-1:0] o_timeout_flags;
    logic               o_irq;

    int fail_count;
    int outstanding;
    int checked;
    bit idle_on = 1'b0;
    int stall_left = 0;
    int cycle_count = 0;
    int reads = 0;
    int writes = 0;
    int ticks = 0;
    int no_ops = 0;

    periodic_interval_timer_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_reg_addr     (i_reg_addr),
        .i_write_data   (i_write_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_data    (o_read_data),
        .o_timeout_flags(o_timeout_flags),
        .o_irq          (o_irq)
    );

    periodic_interval_timer_checker status_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_reg_addr     (i_reg_addr),
        .i_write_data   (i_write_data),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_read_data    (o_read_data),
        .i_timeout_flags(o_timeout_flags),
        .i_irq          (o_irq),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding),
        .o_checked      (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 99) < 20) stall_left <= gap_length();
        end
    end

    task automatic issue(input t_op op, input logic [ADDR_W-1:0] addr,
                         input logic [DATA_W-1:0] data);
        int gap;
        i_in_valid <= 1'b1;
        i_op <= op;
        i_reg_addr <= addr;
        i_write_data <= data;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        case (op)
            OP_READ:  reads++;
            OP_WRITE: writes++;
            OP_TICK:  ticks++;
            default:  no_ops++;
        endcase
        gap = (idle_on && $urandom_range(0, 99) < 25) ? gap_length() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic program_timer();
        int c;
        issue(OP_WRITE, ADDR_MTLOAD0, DATA_W'($urandom_range(0, 3)));
        issue(OP_WRITE, ADDR_MTLOAD1, DATA_W'($urandom_range(0, 3)));
        for (c = 0; c < ADDR_CH_SLOTS; c++) begin
            issue(OP_WRITE, ADDR_CHLOAD0 + ADDR_W'(c), DATA_W'($urandom_range(0, 12)));
        end
        issue(OP_WRITE, ADDR_MUX, DATA_W'($urandom));
        issue(OP_WRITE, ADDR_INTE, DATA_W'($urandom));
        issue(OP_WRITE, ADDR_CHEN, '1);
        issue(OP_WRITE, ADDR_FORCELOAD, '1);
        issue(OP_WRITE, ADDR_CTRL, (DATA_W'(1) << CTRL_ENABLE_BIT) | DATA_W'(3));
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("periodic_interval_timer_top_tb failed");
        $finish;
    end

    initial begin
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        int                roll;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(OP_READ, ADDR_CTRL, '0);
        issue(OP_READ, ADDR_CHLOAD0 + ADDR_W'(3), '0);
        issue(OP_READ, ADDR_COUNT0, '0);
        issue(OP_WRITE, ADDR_MTLOAD0, '1);
        issue(OP_WRITE, ADDR_MTLOAD1, '0);
        issue(OP_WRITE, ADDR_CHLOAD0, '0);
        issue(OP_WRITE, ADDR_CHLOAD0 + ADDR_W'(1), '1);
        issue(OP_WRITE, ADDR_CHLOAD0 + ADDR_W'(2), DATA_W'(1));
        issue(OP_WRITE, ADDR_MUX, 16'hFFF5);
        issue(OP_WRITE, ADDR_INTE, '1);
        issue(OP_WRITE, ADDR_CHEN, 16'hFFF5);
        issue(OP_TICK, '0, '0);
        issue(OP_WRITE, ADDR_CTRL, '1);
        repeat (3) issue(OP_TICK, '1, '1);
        issue(OP_READ, ADDR_FLAGS, '0);
        issue(OP_WRITE, ADDR_FLAGS, DATA_W'(1));
        issue(OP_WRITE, ADDR_COUNT0 + ADDR_W'(2), 16'h1234);
        issue(OP_READ, ADDR_COUNT0 + ADDR_W'(2), '0);
        issue(OP_WRITE, ADDR_FORCELOAD, '1);
        issue(OP_NONE, ADDR_FLAGS, '1);
        issue(OP_WRITE, ADDR_CTRL, '0);
        issue(OP_TICK, '0, '0);
        issue(OP_READ, ADDR_MTLOAD0, '0);
        wait_for_drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            idle_on <= (phase != 0);
            program_timer();
            for (int i = 0; i < PHASE_BEATS; i++) begin
                roll = $urandom_range(0, 99);
                addr = ADDR_W'($urandom_range(0, 15));
                data = DATA_W'($urandom);
                if (roll < 50) begin
                    op = OP_TICK;
                end else if (roll < 75) begin
                    op = OP_WRITE;
                    if (addr == ADDR_CTRL) begin
                        data[CTRL_ENABLE_BIT] = ($urandom_range(0, 99) < 85);
                    end else if ((addr == ADDR_MTLOAD0 || addr == ADDR_MTLOAD1)
                                 && $urandom_range(0, 99) < 80) begin
                        data = DATA_W'($urandom_range(0, 3));
                    end else if (addr >= ADDR_CHLOAD0 && addr < ADDR_COUNT0
                                 && $urandom_range(0, 99) < 80) begin
                        data = DATA_W'($urandom_range(0, 15));
                    end
                end else if (roll < 95) begin
                    op = OP_READ;
                end else begin
                    op = OP_NONE;
                end
                issue(op, addr, data);
            end
            wait_for_drain();
        end

        repeat (4) @(posedge i_clk);
        $display("Sent %0d beats: %0d ticks, %0d writes, %0d reads, %0d no-ops.",
                 ticks + writes + reads + no_ops, ticks, writes, reads, no_ops);
        $display("Compared %0d status beats over %0d phases with and without stalls.",
                 checked, PHASES);
        if (fail_count == 0 && outstanding == 0) begin
            $display("periodic_interval_timer_top_tb passed");
        end else begin
            $display("periodic_interval_timer_top_tb failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/pit_pkg.sv
design/pit_prescaler.sv
design/pit_channel.sv
design/periodic_interval_timer_top.sv
design/pit_checker.sv
verif/periodic_interval_timer_checker.sv
verif/periodic_interval_timer_top_tb.sv
